/* design/usage_counter_table_with_decay_assert.svh */
// Assertion macros for the usage counter table.
// Used by the top level only.
`ifndef USAGE_COUNTER_TABLE_WITH_DECAY_ASSERT_SVH
`define USAGE_COUNTER_TABLE_WITH_DECAY_ASSERT_SVH
`define UCT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define UCT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* design/uctd_pkg.sv */
// Package for the usage counter table: sizes, command codes, types.
// No dependencies.
package uctd_pkg;
  localparam int unsigned NodeCount = 64;
  localparam int unsigned ConceptCount = 256;
  localparam int unsigned EdgeSlots = 256;
  localparam int unsigned BumpAmount = 1;
  localparam int unsigned NodeAw = (NodeCount > 1) ? $clog2(NodeCount) : 1;
  localparam int unsigned ConceptAw = (ConceptCount > 1) ? $clog2(ConceptCount) : 1;
  localparam int unsigned EdgeAw = (EdgeSlots > 1) ? $clog2(EdgeSlots) : 1;
  localparam int unsigned FillW = $clog2(EdgeSlots + 1);
  localparam int unsigned WalkW = $clog2(ConceptCount + NodeCount + EdgeSlots + 1);
  localparam logic [31:0] BumpLimit = 32'hFFFF_FFF0;
  localparam logic [9:0] ScoreCap = 10'd999;
  localparam int unsigned PaddrW = 1;

  typedef enum logic [2:0] {
    CmdBumpNode = 3'd0, CmdBumpConcept = 3'd1, CmdBumpEdge = 3'd2,
    CmdReadNode = 3'd3, CmdReadConcept = 3'd4, CmdReadEdge = 3'd5,
    CmdDecay = 3'd6, CmdRank = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle, StSearch, StNode, StConcept, StEdge, StDecay, StOut
  } state_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] node_id;
    logic [15:0] cpt_id;
    logic [15:0] edge_from;
    logic [15:0] edge_to;
    logic [16:0] decay_factor;
    logic [15:0] prior_score;
  } in_t;

  typedef struct packed {
    logic [31:0] usage_value;
    logic [9:0] ranked_score;
    logic edge_hit;
    logic edge_dropped;
  } out_t;

  function automatic logic [31:0] bump(input logic [31:0] c);
    bump = (c < BumpLimit) ? c + 32'(BumpAmount) : c;
  endfunction

  function automatic logic [9:0] rank(input logic [31:0] u, input logic [15:0] b);
    logic [16:0] s;
    logic [7:0] bonus;
    bonus = (u > 32'd1000) ? 8'd150 : (u > 32'd500) ? 8'd100 :
            (u > 32'd100) ? 8'd50 : (u > 32'd10) ? 8'd20 : 8'd0;
    s = {1'b0, b} + 17'(bonus);
    rank = (s > 17'(ScoreCap)) ? ScoreCap : s[9:0];
  endfunction
endpackage

/* design/uctd_if.sv */
// Valid/ready channel interfaces for items and results.
// Depends on uctd_pkg.
interface uctd_in_if (input logic clk_i);
  logic valid;
  logic ready;
  uctd_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface uctd_out_if (input logic clk_i);
  logic valid;
  logic ready;
  uctd_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/uctd_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module uctd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

/* design/uctd_scale.sv */
// Decay multiplier: registered 32x17 product, shift and saturate.
// No dependencies.
module uctd_scale (
  input  logic        clk_i,
  input  logic [31:0] count_i,
  input  logic [16:0] factor_i,
  output logic [31:0] scaled_o
);
  logic [48:0] prod_q;
  always_ff @(posedge clk_i) begin
    prod_q <= {17'd0, count_i} * {32'd0, factor_i};
  end
  assign scaled_o = (prod_q[48] != 1'b0) ? 32'hFFFF_FFFF : prod_q[47:16];
endmodule

/* design/usage_counter_table_with_decay.sv */
// Usage counter table with decay: one transaction in, one result out.
// Commands bump, read, decay or rank node, concept and edge counters.
// Items arrive on in_if (valid/ready); one result leaves on out_if per item.
// Node and concept counters share one RAM; the edge keys and counts sit in
// a second RAM. Reset clears control state, then a clearing pass writes zero
// to all NodeCount+ConceptCount counter entries; no item is accepted until
// it ends. Write APB register 0 (enabled) only between items.
// Node and concept bumps, reads and rank read the counter, then present the
// result; while disabled no command changes a counter or an edge slot.
// Edge bump and read fetch and then compare one filled slot after another,
// up to a hit or past the last filled slot; a miss on a bump appends a new
// edge while a slot is free, else the item is flagged as dropped.
// Decay walks every counter, then each filled edge slot, through a read, a
// registered multiply and a write.
// One item is in work at a time; a result waits in the output register
// while the receiver stalls, and the next item is taken once it leaves.
`include "usage_counter_table_with_decay_assert.svh"
module usage_counter_table_with_decay (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  uctd_in_if.sink                     in_if,
  uctd_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uctd_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  localparam int unsigned CntAw = $clog2(uctd_pkg::NodeCount + uctd_pkg::ConceptCount);
  localparam int unsigned CntD = 2 ** CntAw;
  localparam int unsigned EdgeD = 2 ** uctd_pkg::EdgeAw;
  localparam int unsigned CntTotal = uctd_pkg::NodeCount + uctd_pkg::ConceptCount;

  uctd_pkg::state_e state_q, state_d;
  uctd_pkg::in_t in_q, in_d;
  uctd_pkg::out_t res_q, res_d;
  logic enabled_q;
  logic clearing_q, clearing_d;
  logic [uctd_pkg::FillW-1:0] fill_q, fill_d;
  logic [uctd_pkg::WalkW-1:0] idx_q, idx_d;
  logic [1:0] ph_q, ph_d;

  logic c_we, e_we;
  logic [CntAw-1:0] c_addr;
  logic [31:0] c_wdata, c_rdata;
  logic [uctd_pkg::EdgeAw-1:0] e_addr;
  logic [63:0] e_wdata, e_rdata;
  logic [31:0] scale_in, scaled;

  logic node_ok, concept_ok;
  logic [CntAw-1:0] node_addr, concept_addr;
  logic out_held;

  uctd_ram #(.Width(32), .Depth(CntD)) u_cnt_ram (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata));
  uctd_ram #(.Width(64), .Depth(EdgeD)) u_edge_ram (
    .clk_i, .we_i(e_we), .addr_i(e_addr), .wdata_i(e_wdata), .rdata_o(e_rdata));
  uctd_scale u_scale (
    .clk_i, .count_i(scale_in), .factor_i(in_q.decay_factor), .scaled_o(scaled));

  assign pready = 1'b1;
  assign prdata = {31'd0, enabled_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == '0) begin
      enabled_q <= pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uctd_pkg::StIdle;
      clearing_q <= 1'b1;
      fill_q <= '0;
      idx_q <= '0;
      ph_q <= '0;
    end else begin
      state_q <= state_d;
      clearing_q <= clearing_d;
      fill_q <= fill_d;
      idx_q <= idx_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    res_q <= res_d;
  end

  assign in_if.ready = (state_q == uctd_pkg::StIdle) && !clearing_q;
  assign out_if.valid = (state_q == uctd_pkg::StOut);
  assign out_if.data = res_q;
  assign out_held = out_if.valid && !out_if.ready;

  assign node_ok = 32'(in_q.node_id) < uctd_pkg::NodeCount;
  assign concept_ok = 32'(in_q.cpt_id) < uctd_pkg::ConceptCount;
  assign node_addr = CntAw'(in_q.node_id);
  assign concept_addr = CntAw'(32'(in_q.cpt_id) + uctd_pkg::NodeCount);

  always_comb begin
    state_d = state_q;
    in_d = in_q;
    res_d = res_q;
    clearing_d = clearing_q;
    fill_d = fill_q;
    idx_d = idx_q;
    ph_d = ph_q;
    c_we = 1'b0;
    c_addr = CntAw'(idx_q);
    c_wdata = '0;
    e_we = 1'b0;
    e_addr = uctd_pkg::EdgeAw'(idx_q);
    e_wdata = '0;
    scale_in = c_rdata;
    unique case (state_q)
      uctd_pkg::StIdle: begin
        if (clearing_q) begin
          c_we = 1'b1;
          idx_d = idx_q + 1'b1;
          if (32'(idx_q) == CntTotal - 1) begin
            clearing_d = 1'b0;
            idx_d = '0;
          end
        end else if (in_if.valid) begin
          in_d = in_if.data;
          res_d = '0;
          idx_d = '0;
          ph_d = '0;
          state_d = uctd_pkg::StNode;
        end
      end
      uctd_pkg::StNode: begin
        // dispatch; phase 0 issues the read
        ph_d = ph_q + 1'b1;
        c_addr = (in_q.command == uctd_pkg::CmdBumpConcept ||
                  in_q.command == uctd_pkg::CmdReadConcept) ? concept_addr : node_addr;
        if (!enabled_q) begin
          if (in_q.command == uctd_pkg::CmdRank) begin
            res_d.ranked_score = uctd_pkg::rank(32'd0, in_q.prior_score);
          end
          state_d = uctd_pkg::StOut;
        end else begin
          unique case (in_q.command) inside
            uctd_pkg::CmdBumpEdge, uctd_pkg::CmdReadEdge: begin
              state_d = uctd_pkg::StSearch;
              ph_d = '0;
            end
            uctd_pkg::CmdDecay: begin
              state_d = uctd_pkg::StDecay;
              ph_d = '0;
            end
            default: begin
              if (ph_q == 2'd1) begin
                ph_d = ph_q;
                state_d = uctd_pkg::StOut;
                unique case (in_q.command)
                  uctd_pkg::CmdBumpNode: begin
                    c_we = node_ok;
                    c_wdata = uctd_pkg::bump(c_rdata);
                  end
                  uctd_pkg::CmdBumpConcept: begin
                    c_we = concept_ok;
                    c_wdata = uctd_pkg::bump(c_rdata);
                  end
                  uctd_pkg::CmdReadNode:
                    res_d.usage_value = node_ok ? c_rdata : '0;
                  uctd_pkg::CmdReadConcept:
                    res_d.usage_value = concept_ok ? c_rdata : '0;
                  default:
                    res_d.ranked_score = uctd_pkg::rank(node_ok ? c_rdata : '0,
                                                        in_q.prior_score);
                endcase
              end
            end
          endcase
        end
      end
      uctd_pkg::StSearch: begin
        // ph 0: issue read of slot idx; ph 1: compare
        e_addr = uctd_pkg::EdgeAw'(idx_q);
        if (ph_q == 2'd0) begin
          if (idx_q >= uctd_pkg::WalkW'(fill_q)) begin
            state_d = uctd_pkg::StOut;
            if (in_q.command == uctd_pkg::CmdBumpEdge) begin
              if (32'(fill_q) < uctd_pkg::EdgeSlots) begin
                e_we = 1'b1;
                e_addr = uctd_pkg::EdgeAw'(fill_q);
                e_wdata = {in_q.edge_from, in_q.edge_to, 32'(uctd_pkg::BumpAmount)};
                fill_d = fill_q + 1'b1;
              end else begin
                res_d.edge_dropped = 1'b1;
              end
            end
          end else begin
            ph_d = 2'd1;
          end
        end else begin
          if (e_rdata[63:48] == in_q.edge_from && e_rdata[47:32] == in_q.edge_to) begin
            res_d.edge_hit = 1'b1;
            state_d = uctd_pkg::StOut;
            if (in_q.command == uctd_pkg::CmdBumpEdge) begin
              e_we = 1'b1;
              e_wdata = {e_rdata[63:32], uctd_pkg::bump(e_rdata[31:0])};
            end else begin
              res_d.usage_value = e_rdata[31:0];
            end
          end else begin
            idx_d = idx_q + 1'b1;
            ph_d = 2'd0;
          end
        end
      end
      uctd_pkg::StDecay: begin
        // counters first, then filled edge slots; read, multiply, write
        if (32'(idx_q) < CntTotal) begin
          c_addr = CntAw'(idx_q);
          scale_in = c_rdata;
          ph_d = (ph_q == 2'd2) ? 2'd0 : ph_q + 1'b1;
          if (ph_q == 2'd2) begin
            c_we = 1'b1;
            c_wdata = scaled;
            idx_d = idx_q + 1'b1;
          end
        end else begin
          e_addr = uctd_pkg::EdgeAw'(32'(idx_q) - CntTotal);
          scale_in = e_rdata[31:0];
          if (32'(idx_q) - CntTotal >= 32'(fill_q)) begin
            state_d = uctd_pkg::StOut;
          end else begin
            ph_d = (ph_q == 2'd2) ? 2'd0 : ph_q + 1'b1;
            if (ph_q == 2'd2) begin
              e_we = 1'b1;
              e_wdata = {e_rdata[63:32], scaled};
              idx_d = idx_q + 1'b1;
            end
          end
        end
      end
      uctd_pkg::StOut: begin
        if (out_if.ready) begin
          state_d = uctd_pkg::StIdle;
        end
      end
      default: state_d = uctd_pkg::StIdle;
    endcase
  end

  `UCT_ASSERT(a_clear_block, clk_i, rst_ni, clearing_q |-> !in_if.ready, "ready while clearing")
  `UCT_ASSERT(a_fill_bound, clk_i, rst_ni, 32'(fill_q) <= uctd_pkg::EdgeSlots, "fill overflow")
  `UCT_ASSERT(a_out_hold, clk_i, rst_ni, out_held |=> $stable(res_q), "result not held")
endmodule
